FILE: hw/rtl/epoch_to_calendar_date_defines.svh
// Assertion macros for the file that checks this block.
`ifndef EPOCH_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define E2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define E2C_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/e2c_pkg.sv
`default_nettype none
package e2c_pkg;

  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegTzEnable  = 1'b0;
  localparam logic [RegIdxW-1:0] RegZoneOffset = 1'b1;

  // First second of year 10000.
  localparam logic [38:0] SecsLimit = 39'd253402300800;

  localparam logic [22:0] MulDiv125Hi = 23'd4294968;
  localparam logic [30:0] MulDiv125Lo = 31'd1099511628;
  localparam logic [31:0] MulDiv675   = 32'd3257812231;
  localparam logic [22:0] MulDivEra   = 23'd7525902;
  localparam logic [23:0] MulDiv7     = 24'd9586981;
  localparam logic [17:0] MulDiv3600  = 18'd149131;
  localparam logic [18:0] MulDiv1460  = 19'd367720;
  localparam logic [18:0] MulDiv36524 = 19'd470373;
  localparam logic [18:0] MulDiv365   = 19'd367720;
  localparam logic [12:0] MulDiv60    = 13'd4370;
  localparam logic [9:0]  MulDiv100   = 10'd656;
  localparam logic [11:0] MulDiv153   = 12'd3427;

  localparam logic [21:0] EpochShift = 22'd719468;
  localparam logic [17:0] DaysPerEra = 18'd146096;

  typedef struct packed {
    logic              tz_en;
    logic signed [17:0] offset;
  } e2c_cfg_t;

  typedef struct packed {
    logic [37:0] secs;
    logic [9:0]  ms;
    logic        oor;
  } e2c_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [2:0]  weekday;
    logic        out_of_range;
  } e2c_result_t;

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/epoch_to_calendar_date.sv
// A result strobes on done_o after its beat passes the front pipeline, the result queue,
// the back pipeline and its output register. Throughput: one beat per cycle while busy
// is low; the constant-divide pipelines in the front and back take a new beat every cycle
// and the receiver cannot stall, so busy stays low for a FifoDepth above 1. Reset: rst_ni
// clears the pipeline and queue; timezone_enable resets to 1 and zone_offset to 0.
`default_nettype none
`include "epoch_to_calendar_date_defines.svh"
module epoch_to_calendar_date #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [47:0] stamp_value_i,
  output logic        done_o,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o,
  output logic [2:0]  weekday_o,
  output logic        out_of_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  e2c_pkg::e2c_cfg_t    cfg_q;
  e2c_pkg::e2c_item_t   f_item, q_item;
  e2c_pkg::e2c_result_t res;
  logic push, full, empty;
  logic cfg_wr;
  logic [e2c_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tz_en  <= 1'b1;
      cfg_q.offset <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        e2c_pkg::RegTzEnable:   cfg_q.tz_en  <= pwdata[0];
        e2c_pkg::RegZoneOffset: cfg_q.offset <= pwdata[17:0];
        default:                cfg_q.tz_en  <= cfg_q.tz_en;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      e2c_pkg::RegTzEnable:   prdata = {31'd0, cfg_q.tz_en};
      e2c_pkg::RegZoneOffset: prdata = {14'd0, cfg_q.offset};
      default:                prdata = '0;
    endcase
  end

  e2c_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .action_i      (action_i),
    .stamp_value_i (stamp_value_i),
    .cfg_i         (cfg_q),
    .full_i        (full),
    .busy_o        (busy),
    .push_o        (push),
    .item_o        (f_item)
  );

  e2c_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .pop_i   (!empty),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (q_item)
  );

  e2c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!empty),
    .item_i  (q_item),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign year_o         = res.year;
  assign month_o        = res.month;
  assign day_o          = res.day;
  assign hour_o         = res.hour;
  assign minute_o       = res.minute;
  assign second_o       = res.second;
  assign millisecond_o  = res.millisecond;
  assign weekday_o      = res.weekday;
  assign out_of_range_o = res.out_of_range;

  `E2C_ASSERT_IMPLY(a_oor_zero, done_o && out_of_range_o, year_o == 14'd0 && month_o == 4'd0, "out-of-range beat carries a date")
  `E2C_ASSERT_IMPLY(a_month_ok, done_o && !out_of_range_o, month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1, "bad month or day")
  `E2C_ASSERT_IMPLY(a_time_ok, done_o && !out_of_range_o, hour_o <= 5'd23 && weekday_o <= 3'd6 && year_o >= 14'd1970, "bad time of day, weekday or year")
  `E2C_ASSERT(a_never_full, !full, "result queue filled up")

endmodule
`default_nettype wire

FILE: hw/rtl/e2c_front.sv
`default_nettype none
module e2c_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                action_i,
  input  logic [47:0]         stamp_value_i,
  input  e2c_pkg::e2c_cfg_t   cfg_i,
  input  logic                full_i,
  output logic                busy_o,
  output logic                push_o,
  output e2c_pkg::e2c_item_t  item_o
);

  logic adv, accept;
  logic v1_q, v2_q, v3_q;

  logic [44:0] p1;
  logic signed [49:0] off_ext, secs_s_d;
  logic act1_q, act2_q, act3_q;
  logic [15:0] q1_1_q, q1_2_q, q1_3_q;
  logic [21:0] top1_q;
  logic [22:0] low1_q, low2_q;
  logic [2:0]  frac1_q, frac2_q, frac3_q;
  logic signed [49:0] secs1_q, secs2_q, secs3_q;
  logic [21:0] r1_full;
  logic [6:0]  r1_2_q;
  logic [29:0] x3, x3_q;
  logic [60:0] p3;
  logic [22:0] q2_3_q;
  logic [29:0] r2_full;
  logic [38:0] secs_ms;
  logic        oor_ms, oor_s;

  assign adv    = !full_i;
  assign busy_o = full_i;
  assign accept = start_i & adv;

  assign p1      = 45'(stamp_value_i[47:26]) * 45'(e2c_pkg::MulDiv125Hi);
  assign off_ext = cfg_i.tz_en ? {{32{cfg_i.offset[17]}}, cfg_i.offset} : 50'sd0;
  assign secs_s_d = $signed({2'b00, stamp_value_i}) - off_ext;

  assign r1_full = top1_q - 22'(q1_1_q) * 22'd125;
  assign x3      = {r1_2_q, low2_q};
  assign p3      = 61'(x3) * 61'(e2c_pkg::MulDiv125Lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act1_q  <= action_i;
      q1_1_q  <= p1[44:29];
      top1_q  <= stamp_value_i[47:26];
      low1_q  <= stamp_value_i[25:3];
      frac1_q <= stamp_value_i[2:0];
      secs1_q <= secs_s_d;

      act2_q  <= act1_q;
      q1_2_q  <= q1_1_q;
      r1_2_q  <= r1_full[6:0];
      low2_q  <= low1_q;
      frac2_q <= frac1_q;
      secs2_q <= secs1_q;

      act3_q  <= act2_q;
      q1_3_q  <= q1_2_q;
      q2_3_q  <= p3[59:37];
      x3_q    <= x3;
      frac3_q <= frac2_q;
      secs3_q <= secs2_q;
    end
  end

  assign r2_full = x3_q - 30'(q2_3_q) * 30'd125;
  assign secs_ms = {q1_3_q, q2_3_q};
  assign oor_ms  = secs_ms >= e2c_pkg::SecsLimit;
  assign oor_s   = secs3_q[49] || (secs3_q[48:0] >= 49'(e2c_pkg::SecsLimit));

  always_comb begin
    if (act3_q) begin
      item_o.secs = secs_ms[37:0];
      item_o.ms   = {r2_full[6:0], frac3_q};
      item_o.oor  = oor_ms;
    end else begin
      item_o.secs = secs3_q[37:0];
      item_o.ms   = 10'd0;
      item_o.oor  = oor_s;
    end
  end

  assign push_o = v3_q & adv;

endmodule
`default_nettype wire

FILE: hw/rtl/e2c_fifo.sv
`default_nettype none
module e2c_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  e2c_pkg::e2c_item_t data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output e2c_pkg::e2c_item_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  e2c_pkg::e2c_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & !full_o;
  assign do_pop  = pop_i & !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/e2c_back.sv
`default_nettype none
module e2c_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  e2c_pkg::e2c_item_t   item_i,
  output logic                 done_o,
  output e2c_pkg::e2c_result_t res_o
);

  logic [7:1] v_q;
  logic [9:0] ms_q [1:7];
  logic       oor_q [1:7];

  // Stage 1
  logic [62:0] p1;
  logic [21:0] days1_q;
  logic [37:0] secs1_q;
  // Stage 2
  logic [37:0] tod2_full;
  logic [21:0] z2_d, wx2_d;
  logic [44:0] p2e;
  logic [45:0] p2w;
  logic [21:0] z2_q, wx2_q;
  logic [4:0]  era2_q;
  logic [16:0] tod2_q;
  logic [19:0] wq2_q;
  // Stage 3
  logic [21:0] doe3_full, wd3_full;
  logic [34:0] p3h;
  logic [17:0] doe3_q;
  logic [4:0]  era3_q, hr3_q;
  logic [16:0] tod3_q;
  logic [2:0]  wd3_q;
  // Stage 4
  logic [36:0] p4a, p4b;
  logic [16:0] rem4_full;
  logic [17:0] doe4_q;
  logic [4:0]  era4_q, hr4_q;
  logic [6:0]  a4_q;
  logic [2:0]  b4_q;
  logic        c4_q;
  logic [11:0] rem4_q;
  logic [2:0]  wd4_q;
  // Stage 5
  logic [17:0] t5;
  logic [36:0] p5y;
  logic [24:0] p5m;
  logic [17:0] doe5_q;
  logic [4:0]  era5_q, hr5_q;
  logic [8:0]  yoe5_q;
  logic [11:0] rem5_q;
  logic [5:0]  mn5_q;
  logic [2:0]  wd5_q;
  // Stage 6
  logic [18:0] p6;
  logic [17:0] base6, doy6_full;
  logic [11:0] sec6_full;
  logic [8:0]  doy6_q, yoe6_q;
  logic [4:0]  era6_q, hr6_q;
  logic [5:0]  mn6_q, sec6_q;
  logic [2:0]  wd6_q;
  // Stage 7
  logic [10:0] mpx7;
  logic [22:0] p7;
  logic [8:0]  doy7_q;
  logic [3:0]  mp7_q;
  logic [13:0] yy7_q;
  logic [4:0]  hr7_q;
  logic [5:0]  mn7_q, sec7_q;
  logic [2:0]  wd7_q;
  // Output
  logic [3:0]  mm8;
  logic [8:0]  day8_full;
  e2c_pkg::e2c_result_t res_d, res_q;
  logic done_q;

  assign p1 = 63'(item_i.secs[37:7]) * 63'(e2c_pkg::MulDiv675);

  assign tod2_full = secs1_q - 38'(days1_q) * 38'd86400;
  assign z2_d      = days1_q + e2c_pkg::EpochShift;
  assign wx2_d     = days1_q + 22'd4;
  assign p2e       = 45'(z2_d) * 45'(e2c_pkg::MulDivEra);
  assign p2w       = 46'(wx2_d) * 46'(e2c_pkg::MulDiv7);

  assign doe3_full = z2_q - 22'(era2_q) * 22'd146097;
  assign wd3_full  = wx2_q - 22'(wq2_q) * 22'd7;
  assign p3h       = 35'(tod2_q) * 35'(e2c_pkg::MulDiv3600);

  assign p4a       = 37'(doe3_q) * 37'(e2c_pkg::MulDiv1460);
  assign p4b       = 37'(doe3_q) * 37'(e2c_pkg::MulDiv36524);
  assign rem4_full = tod3_q - 17'(hr3_q) * 17'd3600;

  assign t5  = doe4_q - 18'(a4_q) + 18'(b4_q) - 18'(c4_q);
  assign p5y = 37'(t5) * 37'(e2c_pkg::MulDiv365);
  assign p5m = 25'(rem4_q) * 25'(e2c_pkg::MulDiv60);

  assign p6        = 19'(yoe5_q) * 19'(e2c_pkg::MulDiv100);
  assign base6     = 18'(yoe5_q) * 18'd365 + 18'(yoe5_q[8:2]) - 18'(p6[18:16]);
  assign doy6_full = doe5_q - base6;
  assign sec6_full = rem5_q - 12'(mn5_q) * 12'd60;

  assign mpx7 = 11'(doy6_q) * 11'd5 + 11'd2;
  assign p7   = 23'(mpx7) * 23'(e2c_pkg::MulDiv153);

  assign mm8       = (mp7_q < 4'd10) ? mp7_q + 4'd3 : mp7_q - 4'd9;
  assign day8_full = doy7_q - e2c_pkg::month_start(mp7_q) + 9'd1;

  always_comb begin
    if (oor_q[7]) begin
      res_d = '0;
      res_d.out_of_range = 1'b1;
    end else begin
      res_d.year         = yy7_q + 14'(mm8 <= 4'd2);
      res_d.month        = mm8;
      res_d.day          = day8_full[4:0];
      res_d.hour         = hr7_q;
      res_d.minute       = mn7_q;
      res_d.second       = sec7_q;
      res_d.millisecond  = ms_q[7];
      res_d.weekday      = wd7_q;
      res_d.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[6:1], valid_i};
      done_q <= v_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q[1]  <= item_i.ms;
    oor_q[1] <= item_i.oor;
    for (int i = 2; i <= 7; i++) begin
      ms_q[i]  <= ms_q[i-1];
      oor_q[i] <= oor_q[i-1];
    end

    days1_q <= p1[62:41];
    secs1_q <= item_i.secs;

    z2_q   <= z2_d;
    wx2_q  <= wx2_d;
    era2_q <= p2e[44:40];
    tod2_q <= tod2_full[16:0];
    wq2_q  <= p2w[45:26];

    doe3_q <= doe3_full[17:0];
    era3_q <= era2_q;
    tod3_q <= tod2_q;
    hr3_q  <= p3h[33:29];
    wd3_q  <= wd3_full[2:0];

    doe4_q <= doe3_q;
    era4_q <= era3_q;
    a4_q   <= p4a[35:29];
    b4_q   <= p4b[36:34];
    c4_q   <= doe3_q == e2c_pkg::DaysPerEra;
    rem4_q <= rem4_full[11:0];
    hr4_q  <= hr3_q;
    wd4_q  <= wd3_q;

    doe5_q <= doe4_q;
    era5_q <= era4_q;
    yoe5_q <= p5y[35:27];
    rem5_q <= rem4_q;
    mn5_q  <= p5m[23:18];
    hr5_q  <= hr4_q;
    wd5_q  <= wd4_q;

    doy6_q <= doy6_full[8:0];
    yoe6_q <= yoe5_q;
    era6_q <= era5_q;
    hr6_q  <= hr5_q;
    mn6_q  <= mn5_q;
    sec6_q <= sec6_full[5:0];
    wd6_q  <= wd5_q;

    doy7_q <= doy6_q;
    mp7_q  <= p7[22:19];
    yy7_q  <= 14'(yoe6_q) + 14'(era6_q) * 14'd400;
    hr7_q  <= hr6_q;
    mn7_q  <= mn6_q;
    sec7_q <= sec6_q;
    wd7_q  <= wd6_q;

    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: sim/epoch_to_calendar_date_tb.sv
`timescale 1ns / 100ps
module epoch_to_calendar_date_tb;

  localparam longint unsigned SecsPerDay = 86400;
  localparam longint unsigned DaysLimit = 2932897;
  localparam longint unsigned LastSec = 64'd253402300799;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = 1'b0;
  logic [47:0] stamp_value_i = '0;
  logic        done_o;
  logic [13:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [9:0]  millisecond_o;
  logic [2:0]  weekday_o;
  logic        out_of_range_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                  tz_enable;
  logic signed [17:0]    zone_ofs;
  e2c_pkg::e2c_result_t  pending_dates[$];
  int unsigned           mismatches = 0;
  int unsigned           cycles = 0;

  epoch_to_calendar_date i_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .stamp_value_i, .done_o,
    .year_o, .month_o, .day_o, .hour_o, .minute_o, .second_o, .millisecond_o,
    .weekday_o, .out_of_range_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  function automatic e2c_pkg::e2c_result_t calendar_of(input logic act,
                                                        input logic [47:0] stamp);
    e2c_pkg::e2c_result_t r;
    longint s, days, tod, z, era, doe, yoe, doy, mp, yy, mm;
    r = '0;
    if (act) begin
      s = longint'(stamp / 48'd1000);
      r.millisecond = 10'(stamp % 48'd1000);
    end else begin
      s = longint'(stamp);
      if (tz_enable) begin
        s = s - longint'(zone_ofs);
      end
    end
    if (s < 0 || s / longint'(SecsPerDay) >= longint'(DaysLimit)) begin
      r = '0;
      r.out_of_range = 1'b1;
      return r;
    end
    days = s / longint'(SecsPerDay);
    tod = s % longint'(SecsPerDay);
    z = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    yy = yoe + era * 400;
    mm = (mp < 10) ? mp + 3 : mp - 9;
    if (mm <= 2) begin
      yy = yy + 1;
    end
    r.year = 14'(yy);
    r.month = 4'(mm);
    r.day = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    r.weekday = 3'((days + 4) % 7);
    return r;
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** epoch_to_calendar_date: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    e2c_pkg::e2c_result_t got, want;
    if (rst_ni && done_o) begin
      got = '{year_o, month_o, day_o, hour_o, minute_o, second_o, millisecond_o,
              weekday_o, out_of_range_o};
      if (pending_dates.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) begin
          $display("unexpected result beat %p", got);
        end
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.hour !== want.hour || got.minute !== want.minute ||
            got.second !== want.second || got.millisecond !== want.millisecond ||
            got.weekday !== want.weekday || got.out_of_range !== want.out_of_range) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch: expected %p", want);
            $display("          actual   %p", got);
          end
        end
      end
    end
  end

  task automatic send_stamp(input logic act, input logic [47:0] stamp);
    int unsigned gap;
    start <= 1'b1;
    action_i <= act;
    stamp_value_i <= stamp;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    pending_dates.push_back(calendar_of(act, stamp));
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(e2c_pkg::RegTzEnable) * 3'd4) begin
      tz_enable = data[0];
    end else if (addr == 3'(e2c_pkg::RegZoneOffset) * 3'd4) begin
      zone_ofs = data[17:0];
    end
    @(posedge clk_i);
  endtask

  task automatic set_zone(input logic en, input logic [17:0] ofs);
    write_reg(3'(e2c_pkg::RegTzEnable) * 3'd4, {31'd0, en});
    write_reg(3'(e2c_pkg::RegZoneOffset) * 3'd4, {{14{ofs[17]}}, ofs});
  endtask

  task automatic test_directed_edges();
    send_stamp(1'b0, 48'd0);
    send_stamp(1'b0, 48'd86399);
    send_stamp(1'b0, 48'd86400);
    send_stamp(1'b0, 48'd951782400);
    send_stamp(1'b0, 48'd4107542399);
    send_stamp(1'b0, 48'd4107542400);
    send_stamp(1'b0, 48'(LastSec));
    send_stamp(1'b0, 48'(LastSec) + 48'd1);
    send_stamp(1'b0, '1);
    send_stamp(1'b1, 48'd0);
    send_stamp(1'b1, 48'd999);
    send_stamp(1'b1, 48'd1000);
    send_stamp(1'b1, '1);
    set_zone(1'b1, 18'd86400);
    send_stamp(1'b0, 48'd0);
    send_stamp(1'b0, 48'd86399);
    send_stamp(1'b0, 48'd86400);
    send_stamp(1'b1, 48'd5);
    set_zone(1'b1, -18'sd86400);
    send_stamp(1'b0, 48'(LastSec) - 48'd86400);
    send_stamp(1'b0, 48'(LastSec) - 48'd86399);
    set_zone(1'b1, 18'h20000);
    send_stamp(1'b0, 48'd0);
    set_zone(1'b1, 18'h1FFFF);
    send_stamp(1'b0, 48'd131071);
    send_stamp(1'b0, 48'd131070);
    set_zone(1'b0, 18'h1FFFF);
    send_stamp(1'b0, 48'd0);
  endtask

  task automatic test_random_stamps(input logic en, input logic [17:0] ofs, input int n);
    logic [47:0] stamp;
    logic        act;
    int unsigned kind;
    set_zone(en, ofs);
    repeat (n) begin
      act = $urandom_range(0, 1);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        stamp = 48'({$urandom, $urandom} % (LastSec + 64'd1));
      end else if (kind < 6) begin
        stamp = 48'($urandom_range(0, 200000));
      end else if (kind < 8) begin
        stamp = 48'(LastSec - 64'd100000 + 64'($urandom_range(0, 200000)));
      end else begin
        stamp = 48'({$urandom, $urandom});
      end
      if (act && kind < 8) begin
        stamp = 48'(stamp * 48'd1000 + 48'($urandom_range(0, 999)));
      end
      send_stamp(act, stamp);
    end
  endtask

  initial begin
    tz_enable = 1'b1;
    zone_ofs = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_stamps(1'b1, 18'd0, 115);
    test_random_stamps(1'b1, 18'd86400, 115);
    test_random_stamps(1'b1, -18'sd86400, 115);
    test_random_stamps(1'b0, 18'h2A5C3, 115);
    test_random_stamps(1'b1, 18'($urandom), 115);
    test_random_stamps(1'b1, 18'h20000, 115);
    drain();
    if (mismatches == 0) begin
      $display("** epoch_to_calendar_date: PASSED **");
    end else begin
      $display("** epoch_to_calendar_date: FAILED **");
    end
    $finish;
  end

endmodule
